### design/bba_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bba_pkg : shared types and constants of the binary buddy allocator
// Word layouts, command structs and the free-bitmap address helpers.
// ----------------------------------------------------------------------------
package bba_pkg;

    localparam int ORDER_MAX  = 10;
    localparam int PAGE_W     = ORDER_MAX;
    localparam int ORD_W      = $clog2(ORDER_MAX + 1);
    localparam int WORD_W     = 32;
    localparam int BIT_W      = 5;
    localparam int POOL_PAGES = 1 << ORDER_MAX;

    // number of bitmap words holding one order's blocks
    function automatic int words_of(input int o);
        return ((1 << (ORDER_MAX - o)) + WORD_W - 1) >> BIT_W;
    endfunction

    function automatic int total_words();
        int s;
        s = 0;
        for (int o = 0; o <= ORDER_MAX; o++) begin
            s += words_of(o);
        end
        return s;
    endfunction

    localparam int FREE_WORDS = total_words();
    localparam int FADDR_W    = (FREE_WORDS > 1) ? $clog2(FREE_WORDS) : 1;
    localparam int USED_WORDS = (POOL_PAGES + WORD_W - 1) / WORD_W;
    localparam int UADDR_W    = (USED_WORDS > 1) ? $clog2(USED_WORDS) : 1;

    // operation and status codes
    localparam logic      OP_ALLOC     = 1'b0;
    localparam logic      OP_FREE      = 1'b1;
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_TOO_LARGE = 2'd1;
    localparam logic [1:0] ST_NO_SPACE  = 2'd2;
    localparam logic [1:0] ST_NOT_ALLOC = 2'd3;

    typedef struct packed {
        logic       operation;
        logic [3:0] req_order;
        logic [9:0] block_index;
    } t_req;

    typedef struct packed {
        logic [9:0] granted_index;
        logic [3:0] result_order;
        logic [1:0] status;
    } t_res;

    // first word of an order inside the free bitmap
    function automatic int word_base(input logic [ORD_W-1:0] ord);
        int b;
        b = 0;
        for (int o = 0; o <= ORDER_MAX; o++) begin
            if (o < int'(ord)) b += words_of(o);
        end
        return b;
    endfunction

    function automatic logic [FADDR_W-1:0] free_addr(input logic [ORD_W-1:0] ord,
                                                     input logic [PAGE_W-1:0] page);
        logic [PAGE_W-1:0] loc;
        loc = page >> ord;
        return FADDR_W'(word_base(ord)) + FADDR_W'(loc >> BIT_W);
    endfunction

    function automatic logic [BIT_W-1:0] free_bit(input logic [ORD_W-1:0] ord,
                                                  input logic [PAGE_W-1:0] page);
        logic [PAGE_W-1:0] loc;
        loc = page >> ord;
        return BIT_W'(loc);
    endfunction

    localparam logic [FADDR_W-1:0] TOP_ADDR = FADDR_W'(word_base(ORD_W'(ORDER_MAX)));

    // free bitmap unit
    typedef enum logic [1:0] {
        BOP_SET  = 2'd0,
        BOP_TCLR = 2'd1,
        BOP_SCAN = 2'd2
    } t_bit_op;

    typedef struct packed {
        logic               valid;
        t_bit_op            op;
        logic [FADDR_W-1:0] addr;
        logic [BIT_W-1:0]   bitpos;
    } t_bit_cmd;

    typedef struct packed {
        logic             done;
        logic             hit;
        logic [BIT_W-1:0] bitpos;
    } t_bit_rsp;

    // page table unit
    typedef enum logic {
        POP_CHECK = 1'b0,
        POP_MARK  = 1'b1
    } t_pg_op;

    typedef struct packed {
        logic              valid;
        t_pg_op            op;
        logic [PAGE_W-1:0] page;
        logic [ORD_W-1:0]  order;
    } t_pg_cmd;

    typedef struct packed {
        logic             done;
        logic             hit;
        logic [ORD_W-1:0] order;
    } t_pg_rsp;

endpackage

### design/bba_bitmem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bba_bitmem : free bitmap with read-modify-write bit unit
// Commands: set a bit, test and clear a bit, or find and take the lowest set
// bit of a word; the word read is registered and the change written back.
// ----------------------------------------------------------------------------
module bba_bitmem
    import bba_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_bit_cmd i_cmd,
    output t_bit_rsp o_rsp
);

    logic [WORD_W-1:0]     mem [FREE_WORDS];
    logic [FREE_WORDS-1:0] r_wvalid;
    logic                  r_busy;
    t_bit_op               r_op;
    logic [FADDR_W-1:0]    r_addr;
    logic [BIT_W-1:0]      r_bit;
    logic [WORD_W-1:0]     r_rdata;
    logic                  r_rvld;

    logic [WORD_W-1:0] word;
    logic [WORD_W-1:0] n_word;
    logic              we;
    logic              hit;
    logic              found;
    logic [BIT_W-1:0]  pos;

    // read the word on command, write the changed word back from the registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.valid) begin
            r_rdata <= mem[i_cmd.addr];
            r_rvld  <= r_wvalid[i_cmd.addr];
            r_op    <= i_cmd.op;
            r_addr  <= i_cmd.addr;
            r_bit   <= i_cmd.bitpos;
        end
        if (r_busy && we) begin
            mem[r_addr] <= n_word;
        end
    end

    // hold word valid bits and the busy flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wvalid <= '0;
            r_busy   <= 1'b0;
        end else begin
            r_busy <= i_cmd.valid;
            if (r_busy && we) r_wvalid[r_addr] <= 1'b1;
        end
    end

    // unwritten words read as the reset map: only the top block free
    always_comb begin
        if (r_rvld) word = r_rdata;
        else if (r_addr == TOP_ADDR) word = WORD_W'(1);
        else word = '0;
    end

    // lowest set bit of the word
    always_comb begin
        found = |word;
        pos   = '0;
        for (int i = WORD_W - 1; i >= 0; i--) begin
            if (word[i]) pos = BIT_W'(i);
        end
    end

    always_comb begin
        n_word = word;
        we     = 1'b0;
        hit    = 1'b0;
        case (r_op)
            BOP_SET: begin
                hit    = word[r_bit];
                n_word = word | (WORD_W'(1) << r_bit);
                we     = 1'b1;
            end
            BOP_TCLR: begin
                hit    = word[r_bit];
                n_word = word & ~(WORD_W'(1) << r_bit);
                we     = word[r_bit];
            end
            BOP_SCAN: begin
                hit    = found;
                n_word = word & ~(WORD_W'(1) << pos);
                we     = found;
            end
            default: begin
                hit = 1'b0;
            end
        endcase
    end

    assign o_rsp.done   = r_busy;
    assign o_rsp.hit    = hit;
    assign o_rsp.bitpos = (r_op == BOP_SCAN) ? pos : r_bit;

endmodule

### design/bba_pagetab.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bba_pagetab : allocated-block marks and stored orders
// Check-and-release or mark a block start page.
// ----------------------------------------------------------------------------
module bba_pagetab
    import bba_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_pg_cmd i_cmd,
    output t_pg_rsp o_rsp
);

    logic [WORD_W-1:0]     used [USED_WORDS];
    logic [ORD_W-1:0]      held [POOL_PAGES];
    logic [USED_WORDS-1:0] r_uvalid;
    logic                  r_busy;
    t_pg_op                r_op;
    logic [UADDR_W-1:0]    r_uaddr;
    logic [BIT_W-1:0]      r_bit;
    logic [WORD_W-1:0]     r_rdata;
    logic                  r_rvld;
    logic [ORD_W-1:0]      r_held;

    logic [UADDR_W-1:0] uaddr;
    logic [WORD_W-1:0]  word;
    logic [WORD_W-1:0]  n_word;
    logic               we;

    assign uaddr = UADDR_W'(i_cmd.page >> BIT_W);
    assign word  = r_rvld ? r_rdata : '0;

    // read on command, store order on mark, write the used word back
    always_ff @(posedge i_clk) begin
        if (i_cmd.valid) begin
            r_rdata <= used[uaddr];
            r_rvld  <= r_uvalid[uaddr];
            r_held  <= held[i_cmd.page];
            r_op    <= i_cmd.op;
            r_uaddr <= uaddr;
            r_bit   <= BIT_W'(i_cmd.page);
            if (i_cmd.op == POP_MARK) held[i_cmd.page] <= i_cmd.order;
        end
        if (r_busy && we) begin
            used[r_uaddr] <= n_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_uvalid <= '0;
            r_busy   <= 1'b0;
        end else begin
            r_busy <= i_cmd.valid;
            if (r_busy && we) r_uvalid[r_uaddr] <= 1'b1;
        end
    end

    always_comb begin
        case (r_op)
            POP_CHECK: begin
                n_word = word & ~(WORD_W'(1) << r_bit);
                we     = word[r_bit];
            end
            POP_MARK: begin
                n_word = word | (WORD_W'(1) << r_bit);
                we     = 1'b1;
            end
            default: begin
                n_word = word;
                we     = 1'b0;
            end
        endcase
    end

    assign o_rsp.done  = r_busy;
    assign o_rsp.hit   = word[r_bit];
    assign o_rsp.order = r_held;

endmodule

### design/binary_buddy_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binary_buddy_allocator : buddy allocator over a pool of 2^ORDER_MAX pages
// Sequencer driving a shared free-bitmap bit unit and a page table.
// ----------------------------------------------------------------------------
// Usage:
//   Input word (i_valid / o_stall): allocate an order or free a block index.
//   Output word (o_valid / i_stall): granted or merged index, order, status.
//   One request is worked at a time; o_stall is high from acceptance until
//   the result has moved into the output register.
//   Allocate: bitmap words are scanned (32 blocks per word) from the requested
//   order upwards, the found block is split down to the requested order and
//   marked in the page table, then the result is handed over and loaded into
//   the output register. Free: page table check, merge steps with the buddy,
//   the final set, then the same hand-over and output load. A rejected order
//   is answered without any bitmap or page table command. The longest
//   request, an order-0 allocate on a wholly free pool, scans 68 words and
//   splits ten times.
//   Reset leaves only the single top-order block free and no block allocated;
//   the maps need no clearing pass.
//   A result waits in the output register while i_stall is high; a finished
//   result that cannot move in holds the sequencer and keeps o_stall high.
// ----------------------------------------------------------------------------
module binary_buddy_allocator
    import bba_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_stall,
    input  t_req i_req,
    output logic o_valid,
    input  logic i_stall,
    output t_res o_res
);

    typedef enum logic [12:0] {
        S_IDLE   = 13'b0000000000001,
        S_ASCAN  = 13'b0000000000010,
        S_ASWAIT = 13'b0000000000100,
        S_ASPLIT = 13'b0000000001000,
        S_APWAIT = 13'b0000000010000,
        S_AMARK  = 13'b0000000100000,
        S_AKWAIT = 13'b0000001000000,
        S_FCHK   = 13'b0000010000000,
        S_FCWAIT = 13'b0000100000000,
        S_FMERGE = 13'b0001000000000,
        S_FMWAIT = 13'b0010000000000,
        S_FSET   = 13'b0100000000000,
        S_FSWAIT = 13'b1000000000000
    } t_state;

    t_state            r_state, n_state;
    logic [ORD_W-1:0]  r_ord, n_ord;
    logic [ORD_W-1:0]  r_req, n_req;
    logic [PAGE_W-1:0] r_page, n_page;
    logic [PAGE_W-1:0] r_word, n_word;
    t_res              r_res, n_res;
    logic              r_pend, n_pend;
    t_res              r_out;
    logic              r_out_valid;

    t_bit_cmd bit_cmd;
    t_bit_rsp bit_rsp;
    t_pg_cmd  pg_cmd;
    t_pg_rsp  pg_rsp;

    logic [PAGE_W-1:0] ord_mask;
    logic [PAGE_W-1:0] scan_page;
    logic              last_word;
    logic              out_free;

    bba_bitmem u_bitmem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (bit_cmd),
        .o_rsp   (bit_rsp)
    );

    bba_pagetab u_pagetab (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (pg_cmd),
        .o_rsp   (pg_rsp)
    );

    assign ord_mask  = PAGE_W'(1) << r_ord;
    assign scan_page = ((r_word << BIT_W) | PAGE_W'(bit_rsp.bitpos)) << r_ord;
    assign last_word = (r_word == PAGE_W'(words_of(int'(r_ord)) - 1));
    assign out_free  = !r_out_valid || !i_stall;
    assign o_stall   = (r_state != S_IDLE) || r_pend;

    // issue commands to the shared units
    always_comb begin
        bit_cmd        = '0;
        bit_cmd.op     = BOP_SET;
        pg_cmd         = '0;
        pg_cmd.op      = POP_CHECK;
        pg_cmd.page    = r_page;
        pg_cmd.order   = r_req;
        case (r_state)
            S_ASCAN: begin
                bit_cmd.valid = 1'b1;
                bit_cmd.op    = BOP_SCAN;
                bit_cmd.addr  = FADDR_W'(word_base(r_ord)) + FADDR_W'(r_word);
            end
            S_ASPLIT: begin
                bit_cmd.valid  = 1'b1;
                bit_cmd.op     = BOP_SET;
                bit_cmd.addr   = free_addr(r_ord, r_page + ord_mask);
                bit_cmd.bitpos = free_bit(r_ord, r_page + ord_mask);
            end
            S_FMERGE: begin
                bit_cmd.valid  = 1'b1;
                bit_cmd.op     = BOP_TCLR;
                bit_cmd.addr   = free_addr(r_ord, r_page ^ ord_mask);
                bit_cmd.bitpos = free_bit(r_ord, r_page ^ ord_mask);
            end
            S_FSET: begin
                bit_cmd.valid  = 1'b1;
                bit_cmd.op     = BOP_SET;
                bit_cmd.addr   = free_addr(r_ord, r_page);
                bit_cmd.bitpos = free_bit(r_ord, r_page);
            end
            S_AMARK: begin
                pg_cmd.valid = 1'b1;
                pg_cmd.op    = POP_MARK;
            end
            S_FCHK: begin
                pg_cmd.valid = 1'b1;
                pg_cmd.op    = POP_CHECK;
            end
            default: begin
                bit_cmd.valid = 1'b0;
            end
        endcase
    end

    // sequencer
    always_comb begin
        n_state = r_state;
        n_ord   = r_ord;
        n_req   = r_req;
        n_page  = r_page;
        n_word  = r_word;
        n_res   = r_res;
        n_pend  = r_pend;
        if (r_pend && out_free) n_pend = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_valid && !r_pend) begin
                    n_word = '0;
                    if (i_req.operation == OP_ALLOC) begin
                        n_ord = ORD_W'(i_req.req_order);
                        n_req = ORD_W'(i_req.req_order);
                        if (int'(i_req.req_order) > ORDER_MAX) begin
                            n_res   = '{granted_index: '0, result_order: '0,
                                        status: ST_TOO_LARGE};
                            n_state = S_FSWAIT;
                        end else begin
                            n_state = S_ASCAN;
                        end
                    end else begin
                        n_page = PAGE_W'(i_req.block_index);
                        if (int'(i_req.block_index) >= POOL_PAGES) begin
                            n_res   = '{granted_index: i_req.block_index,
                                        result_order: '0, status: ST_NOT_ALLOC};
                            n_state = S_FSWAIT;
                        end else begin
                            n_state = S_FCHK;
                        end
                    end
                end
            end
            S_ASCAN:  n_state = S_ASWAIT;
            S_ASWAIT: begin
                if (bit_rsp.done) begin
                    if (bit_rsp.hit) begin
                        n_page = scan_page;
                        if (r_ord == r_req) begin
                            n_state = S_AMARK;
                        end else begin
                            n_ord   = r_ord - 1'b1;
                            n_state = S_ASPLIT;
                        end
                    end else if (!last_word) begin
                        n_word  = r_word + 1'b1;
                        n_state = S_ASCAN;
                    end else if (int'(r_ord) == ORDER_MAX) begin
                        n_res   = '{granted_index: '0, result_order: '0,
                                    status: ST_NO_SPACE};
                        n_state = S_FSWAIT;
                    end else begin
                        n_word  = '0;
                        n_ord   = r_ord + 1'b1;
                        n_state = S_ASCAN;
                    end
                end
            end
            S_ASPLIT: n_state = S_APWAIT;
            S_APWAIT: begin
                if (bit_rsp.done) begin
                    if (r_ord == r_req) begin
                        n_state = S_AMARK;
                    end else begin
                        n_ord   = r_ord - 1'b1;
                        n_state = S_ASPLIT;
                    end
                end
            end
            S_AMARK:  n_state = S_AKWAIT;
            S_AKWAIT: begin
                if (pg_rsp.done) begin
                    n_res   = '{granted_index: 10'(r_page), result_order: 4'(r_req),
                                status: ST_OK};
                    n_state = S_FSWAIT;
                end
            end
            S_FCHK:   n_state = S_FCWAIT;
            S_FCWAIT: begin
                if (pg_rsp.done) begin
                    if (!pg_rsp.hit) begin
                        n_res   = '{granted_index: 10'(r_page), result_order: '0,
                                    status: ST_NOT_ALLOC};
                        n_state = S_FSWAIT;
                    end else if (int'(pg_rsp.order) >= ORDER_MAX) begin
                        n_ord   = ORD_W'(ORDER_MAX);
                        n_state = S_FSET;
                    end else begin
                        n_ord   = pg_rsp.order;
                        n_state = S_FMERGE;
                    end
                end
            end
            S_FMERGE: n_state = S_FMWAIT;
            S_FMWAIT: begin
                if (bit_rsp.done) begin
                    if (bit_rsp.hit) begin
                        n_page = r_page & ~ord_mask;
                        n_ord  = r_ord + 1'b1;
                        n_state = (int'(r_ord) + 1 < ORDER_MAX) ? S_FMERGE : S_FSET;
                    end else begin
                        n_state = S_FSET;
                    end
                end
            end
            S_FSET: begin
                n_res   = '{granted_index: 10'(r_page), result_order: 4'(r_ord),
                            status: ST_OK};
                n_state = S_FSWAIT;
            end
            S_FSWAIT: begin
                // wait for the bit unit when it was used, then load the result
                if (!bit_rsp.done && !r_pend) begin
                    n_pend  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pend  <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ord  <= n_ord;
        r_req  <= n_req;
        r_page <= n_page;
        r_word <= n_word;
        r_res  <= n_res;
    end

    // move a pending result into the output register when it frees
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_pend && out_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_pend && out_free) r_out <= r_res;
    end

    assign o_valid = r_out_valid;
    assign o_res   = r_out;

endmodule

### bench/binary_buddy_allocator_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binary_buddy_allocator_tb : self-checking bench for the buddy allocator
// Drives a directed table of allocate and free words, then random allocates
// and frees (mostly of held pages), and checks every result word against a
// behavioural model of the free lists, the page table and the block orders.
// ----------------------------------------------------------------------------
module binary_buddy_allocator_tb;
    import bba_pkg::*;

    localparam int TREE_SLOTS = (1 << (ORDER_MAX + 1)) - 1;
    localparam int CYCLE_LIMIT = 2000000;

    logic i_clk;
    logic i_rst_n;
    logic i_valid;
    logic o_stall;
    t_req i_req;
    logic o_valid;
    logic i_stall = 1'b0;
    t_res o_res;

    binary_buddy_allocator dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_stall(o_stall),
        .i_req  (i_req),
        .o_valid(o_valid),
        .i_stall(i_stall),
        .o_res  (o_res)
    );

    // model state
    bit       blk_free [TREE_SLOTS];
    bit       page_used [POOL_PAGES];
    bit [3:0] page_order [POOL_PAGES];
    t_res     pending_res[$];
    int       held_pages[$];
    int       errors = 0;
    int       cycles = 0;
    bit       src_done;

    typedef struct {
        t_req req;
        bit   fixed;
        t_res res;
    } t_row;

    t_row rows[$];

    always #1 i_clk = ~i_clk;

    function automatic int slot(input int ord, input int idx);
        return (1 << (ORDER_MAX + 1)) - (1 << (ORDER_MAX + 1 - ord)) + (idx >> ord);
    endfunction

    function automatic void model_reset();
        foreach (blk_free[k]) blk_free[k] = 0;
        foreach (page_used[k]) begin
            page_used[k] = 0;
            page_order[k] = 0;
        end
        blk_free[slot(ORDER_MAX, 0)] = 1;
    endfunction

    // work out the result word of one request and advance the model
    function automatic t_res buddy_predict(input t_req r);
        t_res res;
        int   ord;
        int   idx;
        int   mate;
        bit   found;
        res = '0;
        found = 0;
        idx = 0;
        if (r.operation == OP_ALLOC) begin
            if (r.req_order > ORDER_MAX) begin
                res.status = ST_TOO_LARGE;
                return res;
            end
            for (ord = r.req_order; ord <= ORDER_MAX && !found; ) begin
                for (int k = 0; k < (POOL_PAGES >> ord); k++) begin
                    if (blk_free[slot(ord, k << ord)]) begin
                        idx = k << ord;
                        found = 1;
                        break;
                    end
                end
                if (!found) ord++;
            end
            if (!found) begin
                res.status = ST_NO_SPACE;
                return res;
            end
            blk_free[slot(ord, idx)] = 0;
            while (ord > r.req_order) begin
                ord--;
                blk_free[slot(ord, idx + (1 << ord))] = 1;
            end
            page_used[idx] = 1;
            page_order[idx] = r.req_order;
            held_pages.push_back(idx);
            res.granted_index = idx;
            res.result_order = r.req_order;
            res.status = ST_OK;
        end else begin
            idx = r.block_index;
            if (!page_used[idx]) begin
                res.granted_index = r.block_index;
                res.status = ST_NOT_ALLOC;
                return res;
            end
            page_used[idx] = 0;
            foreach (held_pages[k]) if (held_pages[k] == idx) begin
                held_pages.delete(k);
                break;
            end
            ord = page_order[idx];
            while (ord < ORDER_MAX) begin
                mate = idx ^ (1 << ord);
                if (!blk_free[slot(ord, mate)]) break;
                blk_free[slot(ord, mate)] = 0;
                idx &= ~(1 << ord);
                ord++;
            end
            blk_free[slot(ord, idx)] = 1;
            res.granted_index = idx;
            res.result_order = ord;
            res.status = ST_OK;
        end
        return res;
    endfunction

    // an idle gap before each word, so valid drops before it rises again
    function automatic int pick_gap();
        if ($urandom_range(0, 9) < 7) return $urandom_range(1, 2);
        return $urandom_range(3, 40);
    endfunction

    function automatic t_req word_of(input bit op, input int ord, input int idx);
        t_req r;
        r.operation = op;
        r.req_order = ord;
        r.block_index = idx;
        return r;
    endfunction

    // send one word and queue its expectation
    task automatic send_word(input t_req r, input bit fixed, input t_res want);
        t_res pred;
        int   gap;
        gap = pick_gap();
        repeat (gap) @(posedge i_clk);
        i_valid <= 1'b1;
        i_req <= r;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        i_valid <= 1'b0;
        i_req <= word_of($urandom_range(0, 1), $urandom_range(0, 15), $urandom_range(0, 1023));
        pred = buddy_predict(r);
        if (fixed && pred != want) begin
            $error("table row disagrees with model: %h vs %h", want, pred);
            errors++;
        end
        pending_res.push_back(fixed ? want : pred);
    endtask

    task automatic add_row(input t_req r, input bit fixed, input t_res want);
        t_row w;
        w.req = r;
        w.fixed = fixed;
        w.res = want;
        rows.push_back(w);
    endtask

    function automatic t_res res_of(input int idx, input int ord, input logic [1:0] st);
        t_res res;
        res.granted_index = idx;
        res.result_order = ord;
        res.status = st;
        return res;
    endfunction

    // receiver: random stall and check
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                if (pending_res.size() == 0) begin
                    $error("result word with nothing expected: %h", o_res);
                    errors++;
                end else begin
                    t_res want;
                    want = pending_res.pop_front();
                    if (o_res.granted_index !== want.granted_index) begin
                        $error("granted_index expected %0d got %0d",
                               want.granted_index, o_res.granted_index);
                        errors++;
                    end
                    if (o_res.result_order !== want.result_order) begin
                        $error("result_order expected %0d got %0d",
                               want.result_order, o_res.result_order);
                        errors++;
                    end
                    if (o_res.status !== want.status) begin
                        $error("status expected %0d got %0d", want.status, o_res.status);
                        errors++;
                    end
                end
            end
            if (cycles % 1000 < 150) i_stall <= 1'b0;
            else if ($urandom_range(0, 9) < 8) i_stall <= 1'b0;
            else i_stall <= ($urandom_range(0, 3) != 0);
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAIL binary_buddy_allocator");
            $finish;
        end
    end

    initial begin
        t_req r;
        int   n;
        i_clk = 0;
        i_rst_n = 0;
        i_valid = 0;
        i_req = '0;
        src_done = 0;
        model_reset();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table
        add_row(word_of(OP_FREE, 0, 0), 1, res_of(0, 0, ST_NOT_ALLOC));
        add_row(word_of(OP_ALLOC, 15, 1023), 1, res_of(0, 0, ST_TOO_LARGE));
        add_row(word_of(OP_ALLOC, 11, 0), 1, res_of(0, 0, ST_TOO_LARGE));
        add_row(word_of(OP_ALLOC, 10, 0), 1, res_of(0, 10, ST_OK));
        add_row(word_of(OP_ALLOC, 0, 0), 1, res_of(0, 0, ST_NO_SPACE));
        add_row(word_of(OP_FREE, 0, 0), 1, res_of(0, 10, ST_OK));
        add_row(word_of(OP_ALLOC, 0, 1023), 1, res_of(0, 0, ST_OK));
        add_row(word_of(OP_ALLOC, 0, 0), 1, res_of(1, 0, ST_OK));
        add_row(word_of(OP_ALLOC, 9, 0), 1, res_of(512, 9, ST_OK));
        add_row(word_of(OP_ALLOC, 9, 0), 1, res_of(0, 0, ST_NO_SPACE));
        add_row(word_of(OP_FREE, 0, 1023), 1, res_of(1023, 0, ST_NOT_ALLOC));
        add_row(word_of(OP_FREE, 0, 2), 1, res_of(2, 0, ST_NOT_ALLOC));
        add_row(word_of(OP_ALLOC, 3, 0), 0, '0);
        add_row(word_of(OP_ALLOC, 1, 0), 0, '0);
        add_row(word_of(OP_FREE, 0, 1), 1, res_of(1, 0, ST_OK));
        add_row(word_of(OP_FREE, 15, 1), 1, res_of(1, 0, ST_NOT_ALLOC));
        add_row(word_of(OP_FREE, 0, 0), 0, '0);
        add_row(word_of(OP_FREE, 0, 512), 0, '0);
        add_row(word_of(OP_FREE, 0, 8), 0, '0);
        add_row(word_of(OP_FREE, 0, 2), 0, '0);
        add_row(word_of(OP_ALLOC, 10, 0), 1, res_of(0, 10, ST_OK));
        add_row(word_of(OP_FREE, 0, 0), 1, res_of(0, 10, ST_OK));
        foreach (rows[k]) send_word(rows[k].req, rows[k].fixed, rows[k].res);

        // hold off until every expected word has come back
        while (pending_res.size() != 0) @(posedge i_clk);

        // random part: mostly small allocations and frees of held blocks
        for (n = 0; n < 800; n++) begin
            int pick;
            pick = $urandom_range(0, 99);
            if (pick < 45) begin
                r = word_of(OP_ALLOC, ($urandom_range(0, 9) < 8) ?
                            $urandom_range(0, 4) : $urandom_range(0, 15),
                            $urandom_range(0, 1023));
            end else if (pick < 90 && held_pages.size() != 0) begin
                r = word_of(OP_FREE, $urandom_range(0, 15),
                            held_pages[$urandom_range(0, held_pages.size() - 1)]);
            end else begin
                r = word_of(OP_FREE, $urandom_range(0, 15), $urandom_range(0, 1023));
            end
            send_word(r, 0, '0);
            if (n == 400) while (pending_res.size() != 0) @(posedge i_clk);
        end
        // drain held blocks so merges climb back to the top order
        while (held_pages.size() != 0)
            send_word(word_of(OP_FREE, 0, held_pages[0]), 0, '0);

        while (pending_res.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (errors == 0 && pending_res.size() == 0)
            $display("PASS binary_buddy_allocator");
        else
            $display("FAIL binary_buddy_allocator");
        $finish;
    end

endmodule
